// ===== rtl/core/nst_pkg.sv =====
// shared types, constants and the semitone table of the note sheet tone sequencer
`default_nettype none
package nst_pkg;

  localparam int SHEET_DEPTH_DEF = 256;

  localparam int CMD_W    = 2;
  localparam int SADDR_W  = 8;
  localparam int WORD_W   = 16;
  localparam int DUR_W    = 7;
  localparam int NOTE_W   = 7;
  localparam int VOL_W    = 2;
  localparam int TICK_W   = 15;
  localparam int TU_W     = 13;
  localparam int LEN_W    = 9;
  localparam int PERIOD_W = 15;
  localparam int DUTY_W   = 14;
  localparam int OCT_W    = 4;
  localparam int SEMI_W   = 4;
  localparam int BASE_W   = 12;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;

  localparam int MUL_A_W = 15;
  localparam int MUL_B_W = 13;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK = 2'd0,
    CMD_LOAD = 2'd1,
    CMD_STOP = 2'd2,
    CMD_NOP  = 2'd3
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ENABLE    = 2'd0,
    CFG_TIME_UNIT = 2'd1,
    CFG_SHEET_LEN = 2'd2,
    CFG_UNUSED    = 2'd3
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DUR,
    ST_CMP,
    ST_DEC,
    ST_X3,
    ST_VOL,
    ST_FIN,
    ST_OUT
  } state_t;

  function automatic logic [BASE_W-1:0] semitone(input logic [SEMI_W-1:0] idx);
    logic [BASE_W-1:0] v;
    case (idx)
      4'd0:    v = 12'd3822;
      4'd1:    v = 12'd3607;
      4'd2:    v = 12'd3405;
      4'd3:    v = 12'd3214;
      4'd4:    v = 12'd3033;
      4'd5:    v = 12'd2863;
      4'd6:    v = 12'd2702;
      4'd7:    v = 12'd2551;
      4'd8:    v = 12'd2407;
      4'd9:    v = 12'd2272;
      4'd10:   v = 12'd2145;
      4'd11:   v = 12'd2024;
      default: v = 12'd0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/nst_sheet_mem.sv =====
// sheet word memory, one write and one registered read port
`default_nettype none
module nst_sheet_mem #(
  parameter int DEPTH = nst_pkg::SHEET_DEPTH_DEF,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic                        clk,
  input  wire logic                        we,
  input  wire logic [AW-1:0]               waddr,
  input  wire logic [nst_pkg::WORD_W-1:0]  wdata,
  input  wire logic                        re,
  input  wire logic [AW-1:0]               raddr,
  output logic      [nst_pkg::WORD_W-1:0]  rdata_r
);

  logic [nst_pkg::WORD_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/nst_mul_unit.sv =====
// shared registered multiplier used for duration limit and duty scaling
`default_nettype none
module nst_mul_unit (
  input  wire logic                         clk,
  input  wire logic                         en,
  input  wire logic [nst_pkg::MUL_A_W-1:0]  a,
  input  wire logic [nst_pkg::MUL_B_W-1:0]  b,
  output logic      [nst_pkg::MUL_P_W-1:0]  prod_r
);

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= nst_pkg::MUL_P_W'(a) * nst_pkg::MUL_P_W'(b);
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/nst_note_decode.sv =====
// splits a sheet word and turns its note into a tone period
`default_nettype none
module nst_note_decode (
  input  wire logic [nst_pkg::WORD_W-1:0]   word,
  output logic      [nst_pkg::DUR_W-1:0]    duration,
  output logic      [nst_pkg::VOL_W-1:0]    volume,
  output logic      [nst_pkg::PERIOD_W-1:0] period
);

  logic [nst_pkg::NOTE_W-1:0]   note;
  logic [12:0]                  oct_prod;
  logic [nst_pkg::OCT_W-1:0]    octave;
  logic [nst_pkg::NOTE_W-1:0]   rem;
  logic [nst_pkg::PERIOD_W-1:0] base;

  always_comb begin
    note     = word[8:2];
    duration = word[15:9];
    volume   = word[1:0];
    // divide by twelve through a reciprocal, exact for seven-bit notes
    oct_prod = 13'(note) * 13'd43;
    octave   = oct_prod[12:9];
    rem      = note - (7'(octave) * 7'd12);
    base     = nst_pkg::PERIOD_W'(nst_pkg::semitone(rem[nst_pkg::SEMI_W-1:0]));
    if (octave >= 4'd3) begin
      period = base >> (octave - 4'd3);
    end else begin
      period = base << (4'd3 - octave);
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/note_sheet_tone_sequencer.sv =====
// top level of the note sheet tone sequencer: control sequencer and state registers
//
// input channel in_valid/in_ready carries one command beat: tick, load sheet word or
// stop. each accepted beat gives exactly one result beat on out_valid/out_ready with
// the tone period, duty, sounding flag and whether the beat moved to a new note.
// configuration registers (enable, time_unit, sheet_length) are written through cfg_we/
// cfg_index/cfg_wdata; the user must write them only while the block is idle, the block does not enforce this.
// sequencer steps: load, stop and unused commands go from idle straight to the output
// state; a tick forms the duration limit in the shared multiplier and compares the tick with it,
// and a tick that advances also reads the registered sheet memory, decodes the word and
// passes the times-three and the volume scaling through the same shared multiplier.
// in_ready is high whenever the sequencer is idle, also while a result waits; a result
// stalled by out_ready holds in the output register and the next result waits for it.
// synchronous reset clears playback state and loads the register defaults; the sheet
// memory is not cleared and holds anything until written.
`default_nettype none
module note_sheet_tone_sequencer #(
  parameter int SHEET_DEPTH = nst_pkg::SHEET_DEPTH_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic [nst_pkg::CMD_W-1:0]       in_cmd,
  input  wire logic [nst_pkg::SADDR_W-1:0]     in_sheet_address,
  input  wire logic [nst_pkg::WORD_W-1:0]      in_sheet_word,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic      [nst_pkg::PERIOD_W-1:0]    out_tone_period,
  output logic      [nst_pkg::DUTY_W-1:0]      out_tone_duty,
  output logic                                 out_sounding,
  output logic                                 out_note_advanced,
  input  wire logic                            cfg_we,
  input  wire logic [nst_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [nst_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  localparam int AW = $clog2(SHEET_DEPTH);
  localparam int CW = ((AW > nst_pkg::LEN_W) ? AW : nst_pkg::LEN_W) + 1;

  nst_pkg::state_t state_r, state_nxt;

  logic                           enable_r, enable_nxt;
  logic [nst_pkg::TU_W-1:0]       tu_r, tu_nxt;
  logic [nst_pkg::LEN_W-1:0]      len_r, len_nxt;
  logic [nst_pkg::TICK_W-1:0]     tick_r, tick_nxt;
  logic [AW-1:0]                  pos_r, pos_nxt;
  logic [nst_pkg::DUR_W-1:0]      dur_r, dur_nxt;
  logic [nst_pkg::VOL_W-1:0]      vol_r, vol_nxt;
  logic [nst_pkg::PERIOD_W-1:0]   period_r, period_nxt;
  logic [nst_pkg::DUTY_W-1:0]     duty_r, duty_nxt;
  logic                           on_r, on_nxt;
  logic [nst_pkg::PERIOD_W-1:0]   per_dec_r, per_dec_nxt;
  logic                           adv_r, adv_nxt;
  logic                           out_valid_r, out_valid_nxt;
  logic [nst_pkg::PERIOD_W-1:0]   out_period_r, out_period_nxt;
  logic [nst_pkg::DUTY_W-1:0]     out_duty_r, out_duty_nxt;
  logic                           out_on_r, out_on_nxt;
  logic                           out_adv_r, out_adv_nxt;

  logic                           mem_we, mem_re;
  logic [AW-1:0]                  mem_waddr;
  logic [nst_pkg::WORD_W-1:0]     mem_rdata;
  logic [CW-1:0]                  addr_ext, next_pos;

  logic                           mul_en;
  logic [nst_pkg::MUL_A_W-1:0]    mul_a;
  logic [nst_pkg::MUL_B_W-1:0]    mul_b;
  logic [nst_pkg::MUL_P_W-1:0]    mul_prod;

  logic [nst_pkg::DUR_W-1:0]      dec_dur;
  logic [nst_pkg::VOL_W-1:0]      dec_vol;
  logic [nst_pkg::PERIOD_W-1:0]   dec_period;

  logic                           in_acc;

  nst_sheet_mem #(.DEPTH(SHEET_DEPTH)) u_mem (
    .clk     (clk),
    .we      (mem_we),
    .waddr   (mem_waddr),
    .wdata   (in_sheet_word),
    .re      (mem_re),
    .raddr   (pos_nxt),
    .rdata_r (mem_rdata)
  );

  nst_mul_unit u_mul (
    .clk    (clk),
    .en     (mul_en),
    .a      (mul_a),
    .b      (mul_b),
    .prod_r (mul_prod)
  );

  nst_note_decode u_dec (
    .word     (mem_rdata),
    .duration (dec_dur),
    .volume   (dec_vol),
    .period   (dec_period)
  );

  assign in_ready          = (state_r == nst_pkg::ST_IDLE);
  assign in_acc            = in_valid && in_ready;
  assign out_valid         = out_valid_r;
  assign out_tone_period   = out_period_r;
  assign out_tone_duty     = out_duty_r;
  assign out_sounding      = out_on_r;
  assign out_note_advanced = out_adv_r;

  assign addr_ext  = {{(CW-nst_pkg::SADDR_W){1'b0}}, in_sheet_address};
  assign mem_waddr = addr_ext[AW-1:0];
  assign next_pos  = {{(CW-AW){1'b0}}, pos_r} + CW'(1);

  always_comb begin
    state_nxt      = state_r;
    enable_nxt     = enable_r;
    tu_nxt         = tu_r;
    len_nxt        = len_r;
    tick_nxt       = tick_r;
    pos_nxt        = pos_r;
    dur_nxt        = dur_r;
    vol_nxt        = vol_r;
    period_nxt     = period_r;
    duty_nxt       = duty_r;
    on_nxt         = on_r;
    per_dec_nxt    = per_dec_r;
    adv_nxt        = adv_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_period_nxt = out_period_r;
    out_duty_nxt   = out_duty_r;
    out_on_nxt     = out_on_r;
    out_adv_nxt    = out_adv_r;
    mem_we         = 1'b0;
    mem_re         = 1'b0;
    mul_en         = 1'b0;
    mul_a          = '0;
    mul_b          = '0;

    if (cfg_we) begin
      case (nst_pkg::cfg_idx_t'(cfg_index))
        nst_pkg::CFG_ENABLE:    enable_nxt = cfg_wdata[0];
        nst_pkg::CFG_TIME_UNIT: tu_nxt     = cfg_wdata;
        nst_pkg::CFG_SHEET_LEN: len_nxt    = cfg_wdata[nst_pkg::LEN_W-1:0];
        default: ;
      endcase
    end

    case (state_r)
      nst_pkg::ST_IDLE: begin
        if (in_acc) begin
          adv_nxt   = 1'b0;
          state_nxt = nst_pkg::ST_OUT;
          case (nst_pkg::cmd_t'(in_cmd))
            nst_pkg::CMD_TICK: begin
              tick_nxt  = tick_r + nst_pkg::TICK_W'(1);
              state_nxt = nst_pkg::ST_DUR;
            end
            nst_pkg::CMD_LOAD: begin
              mem_we = (addr_ext < CW'(SHEET_DEPTH));
            end
            nst_pkg::CMD_STOP: begin
              enable_nxt = 1'b0;
              pos_nxt    = '0;
              period_nxt = '0;
              duty_nxt   = '0;
              on_nxt     = 1'b0;
            end
            default: ;
          endcase
        end
      end
      nst_pkg::ST_DUR: begin
        mul_en    = 1'b1;
        mul_a     = nst_pkg::MUL_A_W'(dur_r);
        mul_b     = tu_r;
        state_nxt = nst_pkg::ST_CMP;
      end
      nst_pkg::ST_CMP: begin
        if (enable_r && (nst_pkg::MUL_P_W'(tick_r) > mul_prod)) begin
          tick_nxt = '0;
          if ((next_pos >= CW'(len_r)) || (next_pos >= CW'(SHEET_DEPTH))) begin
            pos_nxt = '0;
          end else begin
            pos_nxt = next_pos[AW-1:0];
          end
          mem_re    = 1'b1;
          adv_nxt   = 1'b1;
          state_nxt = nst_pkg::ST_DEC;
        end else begin
          state_nxt = nst_pkg::ST_OUT;
        end
      end
      nst_pkg::ST_DEC: begin
        dur_nxt     = dec_dur;
        vol_nxt     = dec_vol;
        per_dec_nxt = dec_period;
        state_nxt   = nst_pkg::ST_X3;
      end
      nst_pkg::ST_X3: begin
        mul_en    = 1'b1;
        mul_a     = per_dec_r;
        mul_b     = nst_pkg::MUL_B_W'(3);
        state_nxt = nst_pkg::ST_VOL;
      end
      nst_pkg::ST_VOL: begin
        mul_en    = 1'b1;
        mul_a     = mul_prod[16:2];
        mul_b     = nst_pkg::MUL_B_W'(vol_r);
        state_nxt = nst_pkg::ST_FIN;
      end
      nst_pkg::ST_FIN: begin
        if (vol_r != '0) begin
          period_nxt = per_dec_r;
          duty_nxt   = mul_prod[16:3];
          on_nxt     = 1'b1;
        end else begin
          period_nxt = '0;
          duty_nxt   = '0;
          on_nxt     = 1'b0;
        end
        state_nxt = nst_pkg::ST_OUT;
      end
      nst_pkg::ST_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_period_nxt = period_r;
          out_duty_nxt   = duty_r;
          out_on_nxt     = on_r;
          out_adv_nxt    = adv_r;
          state_nxt      = nst_pkg::ST_IDLE;
        end
      end
      default: state_nxt = nst_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= nst_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r    <= 1'b0;
      tu_r        <= nst_pkg::TU_W'(80);
      len_r       <= nst_pkg::LEN_W'(1);
      tick_r      <= '0;
      pos_r       <= '0;
      dur_r       <= '0;
      vol_r       <= '0;
      period_r    <= '0;
      duty_r      <= '0;
      on_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      enable_r    <= enable_nxt;
      tu_r        <= tu_nxt;
      len_r       <= len_nxt;
      tick_r      <= tick_nxt;
      pos_r       <= pos_nxt;
      dur_r       <= dur_nxt;
      vol_r       <= vol_nxt;
      period_r    <= period_nxt;
      duty_r      <= duty_nxt;
      on_r        <= on_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    per_dec_r    <= per_dec_nxt;
    adv_r        <= adv_nxt;
    out_period_r <= out_period_nxt;
    out_duty_r   <= out_duty_nxt;
    out_on_r     <= out_on_nxt;
    out_adv_r    <= out_adv_nxt;
  end

endmodule
`default_nettype wire
